FILE: rtl/core/bdpa_pkg.sv
// Shared types and constants for the delta patch applier.
// Used by bdpa_ctrl and binary_delta_patch_apply_unit; no dependencies.
package bdpa_pkg;

	// Old image memory geometry.
	localparam int OLD_ADDR_BITS = 16;
	localparam int OLD_DEPTH     = 1 << OLD_ADDR_BITS;

	// Field and register widths.
	localparam int POS_BITS      = 24;
	localparam int OLD_SIZE_BITS = 17;
	localparam int CFG_DATA_BITS = 24;
	localparam int OLDPOS_BITS   = 40;
	localparam int CW_BITS       = 64;
	localparam int MAG_BITS      = 63;
	localparam int IN_DATA_BITS  = 88;
	localparam int OUT_DATA_BITS = 40;

	// Sign-magnitude byte masks for the top byte of a control word.
	localparam logic [7:0] SIGN_BYTE_MASK = 8'h80;
	localparam logic [7:0] MAG_BYTE_MASK  = 8'h7F;

	// Saturation bounds of the signed old position.
	localparam logic [OLDPOS_BITS-1:0] OLDPOS_MAX = {1'b0, {(OLDPOS_BITS-1){1'b1}}};
	localparam logic [OLDPOS_BITS-1:0] OLDPOS_MIN = {1'b1, {(OLDPOS_BITS-1){1'b0}}};

	// Item kinds carried in tuser.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_CONTROL = 2'd1,
		OP_DIFF    = 2'd2,
		OP_EXTRA   = 2'd3
	} op_t;

	// Position in the control word rotation.
	typedef enum logic [1:0] {
		CW_DIFF_LEN  = 2'd0,
		CW_EXTRA_LEN = 2'd1,
		CW_SEEK      = 2'd2
	} cw_idx_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_OLD_SIZE = 1'b0,
		REG_NEW_SIZE = 1'b1
	} cfg_reg_t;

	// Result of one item, as decided when it is accepted.
	typedef struct packed {
		logic                byte_valid;
		logic                is_diff;
		logic                old_hit;
		logic [7:0]          value;
		logic [POS_BITS-1:0] position;
		logic                status;
		logic                finished;
	} step_t;

endpackage

FILE: rtl/core/bdpa_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module bdpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, or read into the output register; the output holds otherwise.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: rtl/core/bdpa_ctrl.sv
// Patch sequencer: configuration registers, control word rotation, counters,
// old and new positions and the corrupt flag. Depends on bdpa_pkg.
module bdpa_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [bdpa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  step_en,
	input  logic [1:0]                            op,
	input  logic [7:0]                            byte_value,
	input  logic [bdpa_pkg::CW_BITS-1:0]          control_word,
	output bdpa_pkg::step_t                       result,
	output logic                                  rd_en,
	output logic [bdpa_pkg::OLD_ADDR_BITS-1:0]    rd_addr
);

	// Configuration registers.
	logic [bdpa_pkg::OLD_SIZE_BITS-1:0] old_size_q;
	logic [bdpa_pkg::POS_BITS-1:0]      new_size_q;

	// Sequencing state.
	bdpa_pkg::cw_idx_t                  cw_idx_q, cw_idx_n;
	logic [bdpa_pkg::POS_BITS-1:0]      new_pos_q, new_pos_n;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   old_pos_q, old_pos_n;
	logic [bdpa_pkg::POS_BITS-1:0]      diff_rem_q, diff_rem_n;
	logic [bdpa_pkg::POS_BITS-1:0]      extra_rem_q, extra_rem_n;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   seek_q, seek_n;
	logic                               corrupt_q, corrupt_n;
	logic                               settle_q, settle_n;

	// Control word decode.
	logic [7:0]                         top_mag;
	logic [bdpa_pkg::MAG_BITS-1:0]      mag;
	logic                               neg;
	logic                               mag_big;
	logic [bdpa_pkg::POS_BITS:0]        sum_diff;
	logic [bdpa_pkg::POS_BITS+1:0]      sum_extra;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   seek_mag;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   seek_val;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   old_pos_inc;
	logic                               old_hit;
	logic [bdpa_pkg::OLDPOS_BITS:0]     settle_sum;
	logic [bdpa_pkg::OLDPOS_BITS-1:0]   settled_pos;

	assign top_mag  = control_word[63:56] & bdpa_pkg::MAG_BYTE_MASK;
	assign mag      = {top_mag[6:0], control_word[55:0]};
	assign neg      = (|(control_word[63:56] & bdpa_pkg::SIGN_BYTE_MASK)) && (|mag);
	assign mag_big  = |mag[bdpa_pkg::MAG_BITS-1:bdpa_pkg::POS_BITS];
	assign sum_diff = {1'b0, new_pos_q} + {1'b0, mag[bdpa_pkg::POS_BITS-1:0]};
	assign sum_extra = {2'b00, new_pos_q} + {2'b00, diff_rem_q}
		+ {2'b00, mag[bdpa_pkg::POS_BITS-1:0]};

	// Seek magnitude saturates at the largest positive old position.
	assign seek_mag = (|mag[bdpa_pkg::MAG_BITS-1:bdpa_pkg::OLDPOS_BITS-1])
		? bdpa_pkg::OLDPOS_MAX : {1'b0, mag[bdpa_pkg::OLDPOS_BITS-2:0]};
	assign seek_val = neg ? (~seek_mag + 1'b1) : seek_mag;

	// Old position after one diff byte, and whether it lies in the old image.
	assign old_pos_inc = (old_pos_q == bdpa_pkg::OLDPOS_MAX) ? old_pos_q : old_pos_q + 1'b1;
	assign old_hit = (old_pos_q[bdpa_pkg::OLDPOS_BITS-1:bdpa_pkg::OLD_ADDR_BITS] == '0)
		&& ({1'b0, old_pos_q[bdpa_pkg::OLD_ADDR_BITS-1:0]} < old_size_q);
	assign rd_addr = old_pos_q[bdpa_pkg::OLD_ADDR_BITS-1:0];

	// Deferred seek: added in the cycle after a block completes, saturating.
	assign settle_sum = {old_pos_q[bdpa_pkg::OLDPOS_BITS-1], old_pos_q}
		+ {seek_q[bdpa_pkg::OLDPOS_BITS-1], seek_q};
	always_comb begin
		settled_pos = settle_sum[bdpa_pkg::OLDPOS_BITS-1:0];
		if (settle_sum[bdpa_pkg::OLDPOS_BITS] != settle_sum[bdpa_pkg::OLDPOS_BITS-1]) begin
			settled_pos = settle_sum[bdpa_pkg::OLDPOS_BITS]
				? bdpa_pkg::OLDPOS_MIN : bdpa_pkg::OLDPOS_MAX;
		end
	end

	// Effect of the item offered at the input, from the present state.
	always_comb begin
		cw_idx_n    = cw_idx_q;
		new_pos_n   = new_pos_q;
		old_pos_n   = old_pos_q;
		diff_rem_n  = diff_rem_q;
		extra_rem_n = extra_rem_q;
		seek_n      = seek_q;
		corrupt_n   = corrupt_q;
		rd_en       = 1'b0;
		result      = '0;
		if (op != bdpa_pkg::OP_LOAD && !corrupt_q) begin
			case (op)
				bdpa_pkg::OP_CONTROL: begin
					case (cw_idx_q)
						bdpa_pkg::CW_DIFF_LEN: begin
							if (diff_rem_q != '0 || extra_rem_q != '0 || new_pos_q >= new_size_q
								|| neg || mag_big || sum_diff > {1'b0, new_size_q}) begin
								corrupt_n = 1'b1;
							end else begin
								diff_rem_n = mag[bdpa_pkg::POS_BITS-1:0];
								cw_idx_n   = bdpa_pkg::CW_EXTRA_LEN;
							end
						end
						bdpa_pkg::CW_EXTRA_LEN: begin
							if (neg || mag_big || sum_extra > {2'b00, new_size_q}) begin
								corrupt_n = 1'b1;
							end else begin
								extra_rem_n = mag[bdpa_pkg::POS_BITS-1:0];
								cw_idx_n    = bdpa_pkg::CW_SEEK;
							end
						end
						default: begin
							seek_n   = seek_val;
							cw_idx_n = bdpa_pkg::CW_DIFF_LEN;
						end
					endcase
				end
				bdpa_pkg::OP_DIFF: begin
					if (cw_idx_q != bdpa_pkg::CW_DIFF_LEN || diff_rem_q == '0) begin
						corrupt_n = 1'b1;
					end else begin
						rd_en             = 1'b1;
						result.byte_valid = 1'b1;
						result.is_diff    = 1'b1;
						result.old_hit    = old_hit;
						result.value      = byte_value;
						new_pos_n         = new_pos_q + 1'b1;
						old_pos_n         = old_pos_inc;
						diff_rem_n        = diff_rem_q - 1'b1;
					end
				end
				default: begin
					if (cw_idx_q != bdpa_pkg::CW_DIFF_LEN || diff_rem_q != '0
						|| extra_rem_q == '0) begin
						corrupt_n = 1'b1;
					end else begin
						result.byte_valid = 1'b1;
						result.value      = byte_value;
						new_pos_n         = new_pos_q + 1'b1;
						extra_rem_n       = extra_rem_q - 1'b1;
					end
				end
			endcase
		end
		settle_n = (op != bdpa_pkg::OP_LOAD) && !corrupt_n && cw_idx_n == bdpa_pkg::CW_DIFF_LEN
			&& diff_rem_n == '0 && extra_rem_n == '0;
		result.position = new_pos_q;
		result.status   = corrupt_n;
		result.finished = new_pos_n >= new_size_q;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_size_q <= '0;
			new_size_q <= '0;
		end else if (cfg_we) begin
			case (bdpa_pkg::cfg_reg_t'(cfg_index))
				bdpa_pkg::REG_OLD_SIZE: old_size_q <= cfg_data[bdpa_pkg::OLD_SIZE_BITS-1:0];
				bdpa_pkg::REG_NEW_SIZE: new_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// State update; a pending seek is folded in before the next block starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_idx_q    <= bdpa_pkg::CW_DIFF_LEN;
			new_pos_q   <= '0;
			old_pos_q   <= '0;
			diff_rem_q  <= '0;
			extra_rem_q <= '0;
			seek_q      <= '0;
			corrupt_q   <= 1'b0;
			settle_q    <= 1'b0;
		end else begin
			if (settle_q) begin
				old_pos_q <= settled_pos;
				seek_q    <= '0;
				settle_q  <= 1'b0;
			end
			if (step_en && op != bdpa_pkg::OP_LOAD && !corrupt_q) begin
				cw_idx_q    <= cw_idx_n;
				new_pos_q   <= new_pos_n;
				diff_rem_q  <= diff_rem_n;
				extra_rem_q <= extra_rem_n;
				corrupt_q   <= corrupt_n;
				if (op == bdpa_pkg::OP_DIFF && !corrupt_n) begin
					old_pos_q <= old_pos_n;
				end
				if (op == bdpa_pkg::OP_CONTROL && cw_idx_q == bdpa_pkg::CW_SEEK) begin
					seek_q <= seek_n;
				end
				if (settle_n) begin
					settle_q <= 1'b1;
				end
			end
		end
	end

	// The corrupt flag is sticky.
	a_corrupt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(corrupt_q))
		else $error("corrupt flag cleared without reset");

	// No old image read may use a position whose seek is still pending.
	a_no_read_on_settle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && rd_en |-> !settle_q)
		else $error("diff byte read while a seek is pending");

	// A seek is only pending right after the rotation returned to the start.
	a_settle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q |-> cw_idx_q == bdpa_pkg::CW_DIFF_LEN && diff_rem_q == '0 && extra_rem_q == '0)
		else $error("seek pending inside a block");

endmodule

FILE: rtl/core/binary_delta_patch_apply_unit.sv
// Top level of the delta patch applier: input handshake, old image memory,
// result pipeline and output register. Depends on bdpa_pkg, bdpa_ram, bdpa_ctrl.
//
//   channel | direction | handshake          | payload
//   s_*     | in        | s_tvalid/s_tready  | tuser op, tdata address/byte/control word
//   m_*     | out       | m_tvalid/m_tready  | tuser byte_valid, tdata byte/position/flags
//   cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; each result passes the old
// image read (stage 1) and the output register (stage 2) after its item is accepted.
// The single memory port serves a load write or a diff byte read per cycle.
// Reset clears the sequencer and pipeline; the old image is not cleared.
// A stall on the output fills the two result stages before the input stalls.
module binary_delta_patch_apply_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// op[1:0]
	input  logic [1:0]                          s_tuser,
	// load_address[15:0], byte_value[23:16], control_word[87:24]
	input  logic [bdpa_pkg::IN_DATA_BITS-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// byte_valid[0]
	output logic                                m_tuser,
	// out_byte[7:0], out_position[31:8], status[32], finished[33], zero fill
	output logic [bdpa_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [bdpa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	logic                                 accept;
	logic                                 s2_free;
	logic                                 s1_adv;
	bdpa_pkg::step_t                      step;
	logic                                 rd_en;
	logic [bdpa_pkg::OLD_ADDR_BITS-1:0]   rd_addr;
	logic                                 is_load;
	logic                                 ram_en;
	logic [bdpa_pkg::OLD_ADDR_BITS-1:0]   ram_addr;
	logic [7:0]                           ram_rdata;
	logic                                 valid_s1;
	bdpa_pkg::step_t                      step_s1;
	logic                                 valid_s2;
	logic                                 byte_valid_s2;
	logic [7:0]                           out_byte_s2;
	logic [bdpa_pkg::POS_BITS-1:0]        position_s2;
	logic                                 status_s2;
	logic                                 finished_s2;
	logic [7:0]                           old_byte;

	// Handshake: the input moves whenever the first result stage can empty.
	assign s2_free  = !valid_s2 || m_tready;
	assign s1_adv   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign accept   = s_tvalid && s_tready;

	bdpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.step_en      (accept),
		.op           (s_tuser),
		.byte_value   (s_tdata[23:16]),
		.control_word (s_tdata[87:24]),
		.result       (step),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr)
	);

	// Old image port: loads write, accepted diff bytes read.
	assign is_load  = s_tuser == bdpa_pkg::OP_LOAD;
	assign ram_en   = accept && (is_load || rd_en);
	assign ram_addr = is_load ? s_tdata[15:0] : rd_addr;

	bdpa_ram #(
		.WIDTH (8),
		.DEPTH (bdpa_pkg::OLD_DEPTH)
	) u_old_image (
		.clk   (clk),
		.en    (ram_en),
		.we    (is_load),
		.addr  (ram_addr),
		.wdata (s_tdata[23:16]),
		.rdata (ram_rdata)
	);

	// Stage 1 waits for the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
	end

	// Diff bytes add the old byte, read as zero outside the old image.
	assign old_byte = step_s1.old_hit ? ram_rdata : 8'h00;

	// Stage 2 is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			byte_valid_s2 <= step_s1.byte_valid;
			out_byte_s2   <= step_s1.is_diff ? step_s1.value + old_byte : step_s1.value;
			position_s2   <= step_s1.position;
			status_s2     <= step_s1.status;
			finished_s2   <= step_s1.finished;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = byte_valid_s2;
	assign m_tdata  = {6'b000000, finished_s2, status_s2, position_s2, out_byte_s2};

	// An accepted item always occupies stage 1 next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// A blocked stage 1 keeps its item.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(step_s1))
		else $error("stage 1 item changed while blocked");

	// A result that carries no byte carries a zero byte.
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step_s1.byte_valid |-> step_s1.value == 8'h00 && !step_s1.is_diff)
		else $error("non-byte result carries data");

endmodule
